@@ design/rbm_pkg.sv @@
package rbm_pkg;

    // RAM sizes in bytes; each must be a power of two.
    localparam int SYSTEM_RAM_BYTES = 8192;
    localparam int CART_RAM_BYTES   = 8192;

    localparam int SYS_AW  = $clog2(SYSTEM_RAM_BYTES);
    localparam int CART_AW = $clog2(CART_RAM_BYTES);

    // Bits of the CPU address that index each RAM (window is 8 KiB).
    localparam int SYS_IDX_BITS  = (SYS_AW < 13) ? SYS_AW : 13;
    localparam int CART_IDX_BITS = (CART_AW < 13) ? CART_AW : 13;

    localparam int CLR_DEPTH = (SYSTEM_RAM_BYTES > CART_RAM_BYTES) ?
                               SYSTEM_RAM_BYTES : CART_RAM_BYTES;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    localparam logic [4:0] ROM_LOG2_MIN   = 5'd13;
    localparam logic [4:0] ROM_LOG2_MAX   = 5'd22;
    localparam logic [4:0] ROM_LOG2_RESET = 5'd15;

    localparam int CART_CTRL_ENABLE_BIT = 3;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_ROM  = 2'd1,
        SRC_CART = 2'd2,
        SRC_SYS  = 2'd3
    } rbm_src_t;

    typedef enum logic {
        FUNC_READ  = 1'b0,
        FUNC_WRITE = 1'b1
    } rbm_func_t;

    typedef struct packed {
        logic              clear;     // clearing pass active
        logic [CLR_AW-1:0] clr_addr;  // entry being cleared
        logic              take;      // request accepted this cycle
        logic              load;      // load the output register
    } rbm_cmd_t;

endpackage

@@ design/rom_bank_memory_mapper_core.sv @@
// Memory mapper for an 8-bit CPU bus: each request is one byte read or write
// at a 16-bit address and returns one result (source, ROM byte address, RAM
// byte). The RAM is read at the accepting edge and its registered data is
// muxed into the output register in the next cycle, so the result is offered
// once that register is loaded; a new request is taken once the result is
// loaded and the output register is free or draining. After reset, both RAMs
// are zeroed by a clearing pass over max(SYSTEM_RAM_BYTES, CART_RAM_BYTES)
// entries (8192 as configured) during which no request is accepted; APB
// writes still work.
// The only APB register, rom_size_log2, lies at addresses 0 to 3 (paddr[2] clear).
module rom_bank_memory_mapper_core
    import rbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [15:0] address,
    input  logic [7:0]  wr_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  source,
    output logic [21:0] rom_address,
    output logic [7:0]  rd_byte
);

    logic [4:0] rom_size_log2_reg;
    rbm_cmd_t   cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(rom_size_log2_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_size_log2_reg <= ROM_LOG2_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        begin
            rom_size_log2_reg <= pwdata[4:0];
        end
    end

    rbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    rbm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rom_size_log2 (rom_size_log2_reg),
        .func          (func),
        .address       (address),
        .wr_byte       (wr_byte),
        .source        (source),
        .rom_address   (rom_address),
        .rd_byte       (rd_byte)
    );

    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !(in_valid && in_ready))
        else $error("request accepted during RAM clearing pass");

    a_take_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> cmd.load)
        else $error("accepted request not loaded into output register");

    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !out_valid)
        else $error("output register overwritten while holding a result");

    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !in_ready)
        else $error("request accepted while previous one is in flight");

endmodule

@@ design/rbm_ram.sv @@
module rbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/rbm_ctrl.sv @@
module rbm_ctrl
    import rbm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output rbm_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_ACCESS = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CLR_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              take;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_AW'(CLR_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                // RAM read data is valid now; output register is free
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cmd.clear    = (state_reg == ST_CLEAR);
    assign cmd.clr_addr = clr_cnt_reg;
    assign cmd.take     = take;
    assign cmd.load     = (state_reg == ST_ACCESS);

endmodule

@@ design/rbm_datapath.sv @@
module rbm_datapath
    import rbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rbm_cmd_t    cmd,
    input  logic [4:0]  rom_size_log2,
    input  logic        func,
    input  logic [15:0] address,
    input  logic [7:0]  wr_byte,
    output logic [1:0]  source,
    output logic [21:0] rom_address,
    output logic [7:0]  rd_byte
);

    logic [7:0]   cart_ctrl_reg;
    logic [7:0]   bank0_reg, bank1_reg, bank2_reg;
    rbm_src_t     src_reg, src_next;
    logic [21:0]  rom_reg, rom_next;
    rbm_src_t     out_src_reg;
    logic [21:0]  out_rom_reg;
    logic [7:0]   out_data_reg;

    logic [4:0]   lg_eff;
    logic [21:0]  rom_mask;
    logic [7:0]   bank;
    logic         is_write;
    logic         cart_on;
    logic         sys_we, cart_we;
    logic [SYS_AW-1:0]  sys_addr;
    logic [CART_AW-1:0] cart_addr;
    logic [7:0]   sys_wdata, cart_wdata;
    logic [7:0]   sys_rdata, cart_rdata;

    assign is_write = (func == FUNC_WRITE);
    assign cart_on  = cart_ctrl_reg[CART_CTRL_ENABLE_BIT];

    always_comb
    begin
        if (rom_size_log2 < ROM_LOG2_MIN)
        begin
            lg_eff = ROM_LOG2_MIN;
        end
        else if (rom_size_log2 > ROM_LOG2_MAX)
        begin
            lg_eff = ROM_LOG2_MAX;
        end
        else
        begin
            lg_eff = rom_size_log2;
        end
    end

    assign rom_mask = 22'((23'd1 << lg_eff) - 23'd1);

    always_comb
    begin
        case (address[15:14])
            2'd0:    bank = bank0_reg;
            2'd1:    bank = bank1_reg;
            default: bank = bank2_reg;
        endcase
    end

    always_comb
    begin
        src_next = SRC_NONE;
        rom_next = '0;
        if (!is_write)
        begin
            if (address >= 16'hC000)
            begin
                src_next = SRC_SYS;
            end
            else if (address < 16'h0400)
            begin
                src_next = SRC_ROM;
                rom_next = 22'(address) & rom_mask;
            end
            else if (address[15:14] == 2'd2 && cart_on)
            begin
                src_next = SRC_CART;
            end
            else
            begin
                src_next = SRC_ROM;
                rom_next = {bank, address[13:0]} & rom_mask;
            end
        end
    end

    // Both RAMs share the clearing pass after reset.
    assign sys_we  = cmd.clear || (cmd.take && is_write && address >= 16'hC000);
    assign cart_we = cmd.clear ||
                     (cmd.take && is_write && address[15:14] == 2'd2 && cart_on);
    assign sys_addr   = cmd.clear ? SYS_AW'(cmd.clr_addr)
                                  : SYS_AW'(address[SYS_IDX_BITS-1:0]);
    assign cart_addr  = cmd.clear ? CART_AW'(cmd.clr_addr)
                                  : CART_AW'(address[CART_IDX_BITS-1:0]);
    assign sys_wdata  = cmd.clear ? 8'd0 : wr_byte;
    assign cart_wdata = cmd.clear ? 8'd0 : wr_byte;

    rbm_ram #(
        .WIDTH (8),
        .DEPTH (SYSTEM_RAM_BYTES)
    ) u_sys_ram (
        .clk   (clk),
        .we    (sys_we),
        .addr  (sys_addr),
        .wdata (sys_wdata),
        .rdata (sys_rdata)
    );

    rbm_ram #(
        .WIDTH (8),
        .DEPTH (CART_RAM_BYTES)
    ) u_cart_ram (
        .clk   (clk),
        .we    (cart_we),
        .addr  (cart_addr),
        .wdata (cart_wdata),
        .rdata (cart_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cart_ctrl_reg <= 8'd0;
            bank0_reg     <= 8'd0;
            bank1_reg     <= 8'd1;
            bank2_reg     <= 8'd2;
        end
        else if (cmd.take && is_write && address >= 16'hFFFC)
        begin
            case (address[1:0])
                2'd0:    cart_ctrl_reg <= wr_byte;
                2'd1:    bank0_reg     <= wr_byte;
                2'd2:    bank1_reg     <= wr_byte;
                default: bank2_reg     <= wr_byte;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            src_reg <= src_next;
            rom_reg <= rom_next;
        end
        if (cmd.load)
        begin
            out_src_reg <= src_reg;
            out_rom_reg <= rom_reg;
            case (src_reg)
                SRC_SYS:  out_data_reg <= sys_rdata;
                SRC_CART: out_data_reg <= cart_rdata;
                default:  out_data_reg <= 8'd0;
            endcase
        end
    end

    assign source      = out_src_reg;
    assign rom_address = out_rom_reg;
    assign rd_byte     = out_data_reg;

endmodule
